// ===== rtl/mrs_pkg.sv =====
// ============================================================================
// mrs_pkg - shared constants and helpers for the Modbus RTU slave engine
// Sizes of the register maps, protocol codes and the CRC-16 byte update.
// ============================================================================
package mrs_pkg;

    localparam int HOLDING_REGS   = 32;
    localparam int INPUT_REGS     = 32;
    localparam int COIL_BYTES     = 8;
    localparam int DISCRETE_BYTES = 8;
    localparam int FRAME_BYTES    = 64;
    localparam int TX_CAP         = 64;

    localparam int COIL_BITS = COIL_BYTES * 8;
    localparam int DISC_BITS = DISCRETE_BYTES * 8;
    localparam int BIT_VW    = (COIL_BITS > DISC_BITS) ? COIL_BITS : DISC_BITS;
    localparam int COIL_BW   = $clog2(COIL_BITS);
    localparam int HOLD_AW   = (HOLDING_REGS > 1) ? $clog2(HOLDING_REGS) : 1;
    localparam int IN_AW     = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;
    localparam int FRAME_AW  = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  EXC_FLAG = 8'h80;
    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    // input item kinds
    localparam logic [2:0] MODE_RX        = 3'd0;
    localparam logic [2:0] MODE_SET_INPUT = 3'd1;
    localparam logic [2:0] MODE_SET_DISC  = 3'd2;
    localparam logic [2:0] MODE_GET_HOLD  = 3'd3;
    localparam logic [2:0] MODE_GET_COIL  = 3'd4;

    // function codes
    localparam logic [7:0] FC_READ_COILS  = 8'd1;
    localparam logic [7:0] FC_READ_DISC   = 8'd2;
    localparam logic [7:0] FC_READ_HOLD   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT  = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_REG   = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

    // exception codes
    localparam logic [7:0] EXC_NONE       = 8'd0;
    localparam logic [7:0] EXC_BAD_FUNC   = 8'd1;
    localparam logic [7:0] EXC_BAD_ADDR   = 8'd2;
    localparam logic [7:0] EXC_BAD_VALUE  = 8'd3;
    localparam logic [7:0] EXC_DEV_FAIL   = 8'd4;

    // Fold one byte into a reflected CRC-16.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/mrs_ram.sv =====
// ============================================================================
// mrs_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module mrs_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/modbus_rtu_slave_engine.sv =====
// ============================================================================
// modbus_rtu_slave_engine - Modbus RTU slave request/response engine
// Buffers a request frame, checks it, serves it and streams the response.
// ============================================================================
// Usage:
// - cfg channel: write the station address (reset value 1) while idle.
// - s_axis: one transfer per item. tuser selects the kind: received byte
//   (tlast marks the frame end), set input register, set discrete byte,
//   read holding register, read coil byte.
// - m_axis: response bytes (tuser 0, tlast on the CRC high byte) or one
//   local read result (tuser 1, tlast 1, value in the upper tdata bits).
// A received byte or a local write is taken in ST_IDLE, which stays ready; a
// coil read goes to ST_LOUT, a holding register read to ST_LRD, then ST_LOUT.
// At a good frame end it parses (ST_PARSE), checks and runs single writes
// (ST_CHECK), then per coil ST_C15_RD/WR or per register ST_R16_HI/LO/WR
// (frame buffer read port); for a non-broadcast it emits one byte per cycle
// unless stalled, plus an ST_TX_WAIT fetch per register read. s_axis stays
// stalled until the last response byte sits in the output register.
// A stalled receiver simply holds the output register and the emitter.
// Reset sets the address to 1 and clears all register maps and the frame state;
// no clearing pass is needed (holding registers use valid bits).
// ============================================================================
module modbus_rtu_slave_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,       // slave_address
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // rx_byte[7:0], local_index[13:8], local_value[29:14]
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // tx_byte[7:0], read_value[23:8]
    output logic        m_axis_tuser,   // out_kind
    output logic        m_axis_tlast    // tx_last
);
    import mrs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LRD, ST_LOUT, ST_PARSE, ST_CHECK, ST_C15_RD, ST_C15_WR,
        ST_R16_HI, ST_R16_LO, ST_R16_WR, ST_TX, ST_TX_WAIT
    } state_t;

    typedef enum logic [1:0] {RSP_EXC, RSP_BITS, RSP_WORDS, RSP_ECHO} rsp_kind_t;

    // ---------------------------------------------------------------- state
    state_t             state_reg;
    logic [7:0]         slave_addr_reg;
    logic [6:0]         count_reg;
    logic               ovf_reg;
    logic [15:0]        crc_reg;
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;
    logic [15:0]        out_val_reg;
    logic [15:0]        input_regs_reg [INPUT_REGS];
    logic [COIL_BITS-1:0] coil_bits_reg;
    logic [DISC_BITS-1:0] disc_bits_reg;
    logic [HOLDING_REGS-1:0] hold_vld_reg;
    logic [6:0]         i_reg;
    logic [6:0]         tx_pos_reg;
    logic [15:0]        crc_tx_reg;
    logic               fetched_reg;

    // request and response payload
    logic [7:0]         hb_reg [7];
    logic [7:0]         pend_old_reg;
    logic [7:0]         pend_new_reg;
    logic [6:0]         dlen_reg;
    logic               bcast_reg;
    logic [7:0]         func_reg;
    logic [15:0]        start_reg;
    logic [15:0]        qty_reg;
    logic [7:0]         bc_reg;
    rsp_kind_t          rsp_kind_reg;
    logic [6:0]         tlen_reg;
    logic [7:0]         byte2_reg;
    logic [7:0]         func_rsp_reg;
    logic [7:0]         hi_reg;
    logic [15:0]        word_reg;
    logic [6:0]         fidx_reg;
    logic [5:0]         lidx_reg;
    logic [15:0]        lval_reg;

    // ------------------------------------------------------------- input side
    logic        s_fire;
    logic [2:0]  in_mode;
    logic [7:0]  in_byte;
    logic [5:0]  in_idx;
    logic [15:0] in_val;
    logic        in_end;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign in_mode       = s_axis_tuser;
    assign in_byte       = s_axis_tdata[7:0];
    assign in_idx        = s_axis_tdata[13:8];
    assign in_val        = s_axis_tdata[29:14];
    assign in_end        = s_axis_tlast;
    assign cfg_ready     = 1'b1;

    // Receive: keep the CRC two bytes behind the newest byte so that at the
    // frame end it covers everything but the trailing CRC field.
    logic        rx_store;
    logic [6:0]  count_inc;
    logic        ovf_new;
    logic [15:0] crc_step;
    logic        frame_ok;

    always_comb
    begin
        rx_store  = (count_reg < 7'(FRAME_BYTES));
        count_inc = count_reg + {6'd0, rx_store};
        ovf_new   = ovf_reg || !rx_store;
        crc_step  = crc16_byte(crc_reg, pend_old_reg);
        frame_ok  = !ovf_new && (count_inc >= 7'd4)
                    && ((hb_reg[0] == slave_addr_reg) || (hb_reg[0] == 8'h00))
                    && (crc_step == {in_byte, pend_new_reg});
    end

    // ------------------------------------------------------------ header parse
    logic [7:0] hdr [7];

    always_comb
    begin
        for (int h = 0; h < 7; h++)
        begin
            hdr[h] = (dlen_reg > 7'(h)) ? hb_reg[h] : 8'h00;
        end
    end

    // --------------------------------------------------------------- check
    logic [16:0] sum17;
    logic [16:0] bytes17;
    logic [16:0] words17;
    logic [16:0] nbits17;
    logic [7:0]  chk_exc;
    rsp_kind_t   chk_kind;
    logic [6:0]  chk_tlen;
    logic [7:0]  chk_byte2;

    always_comb
    begin
        sum17    = {1'b0, start_reg} + {1'b0, qty_reg};
        bytes17  = ({1'b0, qty_reg} + 17'd7) >> 3;
        words17  = {qty_reg, 1'b0};
        nbits17  = (func_reg == FC_READ_COILS) ? 17'(COIL_BITS) : 17'(DISC_BITS);
        chk_exc  = EXC_NONE;
        chk_kind = RSP_ECHO;
        case (func_reg)
            FC_READ_COILS, FC_READ_DISC:
            begin
                chk_kind = RSP_BITS;
                priority if ({1'b0, start_reg} >= nbits17)               chk_exc = EXC_BAD_ADDR;
                else if (qty_reg == 16'd0 || sum17 > nbits17)            chk_exc = EXC_BAD_VALUE;
                else if (bytes17 > 17'(TX_CAP - 5))                      chk_exc = EXC_DEV_FAIL;
                else                                                     chk_exc = EXC_NONE;
            end
            FC_READ_HOLD, FC_READ_INPUT:
            begin
                chk_kind = RSP_WORDS;
                priority if (func_reg == FC_READ_HOLD ? start_reg >= 16'(HOLDING_REGS)
                                                      : start_reg >= 16'(INPUT_REGS))
                    chk_exc = EXC_BAD_ADDR;
                else if (qty_reg == 16'd0 ||
                         (func_reg == FC_READ_HOLD ? sum17 > 17'(HOLDING_REGS)
                                                   : sum17 > 17'(INPUT_REGS)))
                    chk_exc = EXC_BAD_VALUE;
                else if (words17 > 17'(TX_CAP - 5))
                    chk_exc = EXC_DEV_FAIL;
                else
                    chk_exc = EXC_NONE;
            end
            FC_WRITE_COIL:
            begin
                priority if (start_reg >= 16'(COIL_BITS))                    chk_exc = EXC_BAD_ADDR;
                else if (qty_reg != COIL_ON && qty_reg != COIL_OFF)          chk_exc = EXC_BAD_VALUE;
                else                                                         chk_exc = EXC_NONE;
            end
            FC_WRITE_REG:
            begin
                if (start_reg >= 16'(HOLDING_REGS))
                begin
                    chk_exc = EXC_BAD_ADDR;
                end
            end
            FC_WRITE_COILS:
            begin
                priority if (start_reg >= 16'(COIL_BITS))                    chk_exc = EXC_BAD_ADDR;
                else if (qty_reg == 16'd0 || sum17 > 17'(COIL_BITS))         chk_exc = EXC_BAD_VALUE;
                else if (bytes17 != {9'd0, bc_reg}
                         || ({1'b0, bc_reg} + 9'd7) != {2'd0, dlen_reg})     chk_exc = EXC_DEV_FAIL;
                else                                                         chk_exc = EXC_NONE;
            end
            FC_WRITE_REGS:
            begin
                priority if (start_reg >= 16'(HOLDING_REGS))                 chk_exc = EXC_BAD_ADDR;
                else if (qty_reg == 16'd0 || sum17 > 17'(HOLDING_REGS))      chk_exc = EXC_BAD_VALUE;
                else if (words17 != {9'd0, bc_reg}
                         || ({1'b0, bc_reg} + 9'd7) != {2'd0, dlen_reg})     chk_exc = EXC_DEV_FAIL;
                else                                                         chk_exc = EXC_NONE;
            end
            default:
            begin
                chk_exc = EXC_BAD_FUNC;
            end
        endcase

        if (chk_exc != EXC_NONE)
        begin
            chk_kind  = RSP_EXC;
            chk_tlen  = 7'd3;
            chk_byte2 = chk_exc;
        end
        else
        begin
            unique case (chk_kind)
                RSP_BITS:
                begin
                    chk_tlen  = 7'(17'd3 + bytes17);
                    chk_byte2 = bytes17[7:0];
                end
                RSP_WORDS:
                begin
                    chk_tlen  = 7'(17'd3 + words17);
                    chk_byte2 = words17[7:0];
                end
                default:
                begin
                    chk_tlen  = 7'd6;
                    chk_byte2 = start_reg[15:8];
                end
            endcase
        end
    end

    // --------------------------------------------------------------- memories
    logic                fr_we;
    logic [FRAME_AW-1:0] fr_raddr;
    logic [7:0]          fr_rdata;
    logic [7:0]          fr_raddr_w;

    logic                hr_we;
    logic [HOLD_AW-1:0]  hr_waddr;
    logic [15:0]         hr_wdata;
    logic [HOLD_AW-1:0]  hr_raddr;
    logic [15:0]         hr_rdata;
    logic [6:0]          loop_idx;

    assign fr_we    = s_fire && (in_mode == MODE_RX) && rx_store;
    assign loop_idx = start_reg[6:0] + i_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_C15_RD: fr_raddr_w = 8'd7 + {4'd0, i_reg[6:3]};
            ST_R16_LO: fr_raddr_w = 8'd8 + {i_reg, 1'b0};
            default:   fr_raddr_w = 8'd7 + {i_reg, 1'b0};
        endcase
        fr_raddr = fr_raddr_w[FRAME_AW-1:0];
    end

    mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (count_reg[FRAME_AW-1:0]),
        .wdata (in_byte),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    // ------------------------------------------------------------- emitter
    logic        load_ok;
    logic [6:0]  k;
    logic        need_fetch;
    logic [6:0]  fetch_idx;
    logic [6:0]  bit_off;
    logic [BIT_VW-1:0] bit_src;
    logic [BIT_VW-1:0] bit_shift;
    logic [7:0]  bit_rem;
    logic [7:0]  bit_mask;
    logic [7:0]  tx_sel;
    logic        emit;
    logic        emit_kind;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic [15:0] emit_val;
    logic [7:0]  coil_sel;
    logic [15:0] crc_tx_next;

    always_comb
    begin
        load_ok    = !out_valid_reg || m_axis_tready;
        k          = tx_pos_reg - 7'd3;
        need_fetch = (rsp_kind_reg == RSP_WORDS) && (tx_pos_reg >= 7'd3)
                     && (tx_pos_reg < tlen_reg) && !k[0] && !fetched_reg;
        fetch_idx  = start_reg[6:0] + {1'b0, k[6:1]};
        bit_off    = start_reg[6:0] + {k[3:0], 3'b000};
        bit_src    = (func_reg == FC_READ_COILS) ? BIT_VW'(coil_bits_reg)
                                                 : BIT_VW'(disc_bits_reg);
        bit_shift  = bit_src >> bit_off;
        bit_rem    = qty_reg[7:0] - {k[4:0], 3'b000};
        bit_mask   = (bit_rem >= 8'd8) ? 8'hFF : ~(8'hFF << bit_rem[2:0]);

        priority if (tx_pos_reg == 7'(tlen_reg + 7'd1)) tx_sel = crc_tx_reg[15:8];
        else if (tx_pos_reg == tlen_reg)                tx_sel = crc_tx_reg[7:0];
        else if (tx_pos_reg == 7'd0)                    tx_sel = slave_addr_reg;
        else if (tx_pos_reg == 7'd1)                    tx_sel = func_rsp_reg;
        else if (tx_pos_reg == 7'd2)                    tx_sel = byte2_reg;
        else
        begin
            unique case (rsp_kind_reg)
                RSP_BITS:  tx_sel = bit_shift[7:0] & bit_mask;
                RSP_WORDS: tx_sel = k[0] ? word_reg[7:0] : word_reg[15:8];
                RSP_ECHO:  tx_sel = (tx_pos_reg == 7'd3) ? start_reg[7:0]
                                  : (tx_pos_reg == 7'd4) ? qty_reg[15:8] : qty_reg[7:0];
                default:   tx_sel = 8'h00;
            endcase
        end
        crc_tx_next = crc16_byte(crc_tx_reg, tx_sel);

        coil_sel = 8'h00;
        for (int b = 0; b < COIL_BYTES; b++)
        begin
            if (in_idx == 6'(b))
            begin
                coil_sel = coil_bits_reg[b*8 +: 8];
            end
        end

        emit      = 1'b0;
        emit_kind = 1'b0;
        emit_byte = tx_sel;
        emit_last = (tx_pos_reg == 7'(tlen_reg + 7'd1));
        emit_val  = 16'h0000;
        if (state_reg == ST_TX)
        begin
            emit = load_ok && !need_fetch;
        end
        else if (state_reg == ST_LOUT)
        begin
            emit      = load_ok;
            emit_kind = 1'b1;
            emit_byte = 8'h00;
            emit_last = 1'b1;
            emit_val  = lval_reg;
        end
    end

    // holding register memory: single writes, block writes, local and bus reads
    always_comb
    begin
        hr_we    = ((state_reg == ST_CHECK) && (chk_exc == EXC_NONE)
                    && (func_reg == FC_WRITE_REG)) || (state_reg == ST_R16_WR);
        hr_waddr = (state_reg == ST_CHECK) ? start_reg[HOLD_AW-1:0] : loop_idx[HOLD_AW-1:0];
        hr_wdata = (state_reg == ST_CHECK) ? qty_reg : {hi_reg, fr_rdata};
        hr_raddr = (state_reg == ST_IDLE) ? in_idx[HOLD_AW-1:0] : fetch_idx[HOLD_AW-1:0];
    end

    mrs_ram #(.WIDTH(16), .DEPTH(HOLDING_REGS)) u_hold_ram (
        .clk   (clk),
        .we    (hr_we),
        .waddr (hr_waddr),
        .wdata (hr_wdata),
        .raddr (hr_raddr),
        .rdata (hr_rdata)
    );

    // ------------------------------------------------------ control sequencer
    state_t done_st;
    assign done_st = bcast_reg ? ST_IDLE : ST_TX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slave_addr_reg <= 8'd1;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            crc_reg        <= CRC_INIT;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_val_reg    <= '0;
            for (int r = 0; r < INPUT_REGS; r++)
            begin
                input_regs_reg[r] <= '0;
            end
            coil_bits_reg  <= '0;
            disc_bits_reg  <= '0;
            hold_vld_reg   <= '0;
            i_reg          <= '0;
            tx_pos_reg     <= '0;
            crc_tx_reg     <= CRC_INIT;
            fetched_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                slave_addr_reg <= cfg_data;
            end

            // output register: load a new transfer or drop the taken one
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= emit_kind;
                out_byte_reg  <= emit_byte;
                out_last_reg  <= emit_last;
                out_val_reg   <= emit_val;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (hr_we)
            begin
                hold_vld_reg[hr_waddr] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        case (in_mode)
                            MODE_RX:
                            begin
                                if (rx_store)
                                begin
                                    count_reg <= count_inc;
                                    if (count_reg >= 7'd2)
                                    begin
                                        crc_reg <= crc_step;
                                    end
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                                if (in_end)
                                begin
                                    count_reg <= '0;
                                    ovf_reg   <= 1'b0;
                                    crc_reg   <= CRC_INIT;
                                    if (frame_ok)
                                    begin
                                        state_reg <= ST_PARSE;
                                    end
                                end
                            end
                            MODE_SET_INPUT:
                            begin
                                if ({1'b0, in_idx} < 7'(INPUT_REGS))
                                begin
                                    input_regs_reg[in_idx[IN_AW-1:0]] <= in_val;
                                end
                            end
                            MODE_SET_DISC:
                            begin
                                for (int b = 0; b < DISCRETE_BYTES; b++)
                                begin
                                    if (in_idx == 6'(b))
                                    begin
                                        disc_bits_reg[b*8 +: 8] <= in_val[7:0];
                                    end
                                end
                            end
                            MODE_GET_HOLD: state_reg <= ST_LRD;
                            MODE_GET_COIL: state_reg <= ST_LOUT;
                            default: ;
                        endcase
                    end
                end
                ST_LRD:
                begin
                    state_reg <= ST_LOUT;
                end
                ST_LOUT:
                begin
                    if (load_ok)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PARSE:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    tx_pos_reg  <= '0;
                    crc_tx_reg  <= CRC_INIT;
                    fetched_reg <= 1'b0;
                    i_reg       <= '0;
                    state_reg   <= done_st;
                    if (chk_exc == EXC_NONE)
                    begin
                        if (func_reg == FC_WRITE_COIL)
                        begin
                            coil_bits_reg[start_reg[COIL_BW-1:0]] <= (qty_reg == COIL_ON);
                        end
                        if (func_reg == FC_WRITE_COILS)
                        begin
                            state_reg <= ST_C15_RD;
                        end
                        if (func_reg == FC_WRITE_REGS)
                        begin
                            state_reg <= ST_R16_HI;
                        end
                    end
                end
                ST_C15_RD:
                begin
                    state_reg <= ST_C15_WR;
                end
                ST_C15_WR:
                begin
                    coil_bits_reg[loop_idx[COIL_BW-1:0]] <= fr_rdata[i_reg[2:0]];
                    i_reg <= i_reg + 7'd1;
                    if ({9'd0, i_reg + 7'd1} == qty_reg)
                    begin
                        state_reg <= done_st;
                    end
                    else
                    begin
                        state_reg <= ST_C15_RD;
                    end
                end
                ST_R16_HI:
                begin
                    state_reg <= ST_R16_LO;
                end
                ST_R16_LO:
                begin
                    state_reg <= ST_R16_WR;
                end
                ST_R16_WR:
                begin
                    i_reg <= i_reg + 7'd1;
                    if ({9'd0, i_reg + 7'd1} == qty_reg)
                    begin
                        state_reg <= done_st;
                    end
                    else
                    begin
                        state_reg <= ST_R16_HI;
                    end
                end
                ST_TX:
                begin
                    if (need_fetch)
                    begin
                        state_reg <= ST_TX_WAIT;
                    end
                    else if (load_ok)
                    begin
                        tx_pos_reg <= tx_pos_reg + 7'd1;
                        if (tx_pos_reg < tlen_reg)
                        begin
                            crc_tx_reg <= crc_tx_next;
                        end
                        if ((rsp_kind_reg == RSP_WORDS) && (tx_pos_reg >= 7'd3) && k[0])
                        begin
                            fetched_reg <= 1'b0;
                        end
                        if (emit_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_TX_WAIT:
                begin
                    fetched_reg <= 1'b1;
                    state_reg   <= ST_TX;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ----------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire && (in_mode == MODE_RX) && rx_store)
        begin
            pend_old_reg <= pend_new_reg;
            pend_new_reg <= in_byte;
            if (count_reg < 7'd7)
            begin
                hb_reg[count_reg[2:0]] <= in_byte;
            end
        end
        if (s_fire && (in_mode == MODE_RX) && in_end)
        begin
            dlen_reg  <= count_inc - 7'd2;
            bcast_reg <= (hb_reg[0] == 8'h00);
        end
        if (s_fire)
        begin
            lidx_reg <= in_idx;
            lval_reg <= coil_sel;
        end
        if (state_reg == ST_LRD)
        begin
            lval_reg <= (({1'b0, lidx_reg} < 7'(HOLDING_REGS))
                         && hold_vld_reg[lidx_reg[HOLD_AW-1:0]]) ? hr_rdata : 16'h0000;
        end
        if (state_reg == ST_PARSE)
        begin
            func_reg  <= hdr[1];
            start_reg <= {hdr[2], hdr[3]};
            qty_reg   <= {hdr[4], hdr[5]};
            bc_reg    <= hdr[6];
        end
        if (state_reg == ST_CHECK)
        begin
            rsp_kind_reg <= chk_kind;
            tlen_reg     <= chk_tlen;
            byte2_reg    <= chk_byte2;
            func_rsp_reg <= (chk_exc != EXC_NONE) ? (func_reg | EXC_FLAG) : func_reg;
        end
        if (state_reg == ST_R16_LO)
        begin
            hi_reg <= fr_rdata;
        end
        if ((state_reg == ST_TX) && need_fetch)
        begin
            fidx_reg <= fetch_idx;
        end
        if (state_reg == ST_TX_WAIT)
        begin
            if (func_reg == FC_READ_HOLD)
            begin
                word_reg <= hold_vld_reg[fidx_reg[HOLD_AW-1:0]] ? hr_rdata : 16'h0000;
            end
            else
            begin
                word_reg <= input_regs_reg[fidx_reg[IN_AW-1:0]];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_val_reg, out_byte_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------ assertions
    a_local_read_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg) |-> (out_last_reg && out_byte_reg == 8'h00))
        else $error("local read result without last or with a response byte");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 7'(FRAME_BYTES))
        else $error("frame count beyond buffer");

    a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_C15_WR || state_reg == ST_R16_WR) |-> ({9'd0, i_reg} < qty_reg))
        else $error("write loop ran past the quantity");

    a_tx_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TX) |-> (tx_pos_reg <= 7'(tlen_reg + 7'd1)))
        else $error("response position past the CRC");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_mode == MODE_RX && in_end && frame_ok) |=> !s_axis_tready)
        else $error("input taken while a frame is being served");

endmodule
